/* sv/rvm_pkg.sv */
// shared types, constants and fixed-point helpers for the rotation vector to matrix block
// no dependencies
`default_nettype none

package rvm_pkg;

	// pipeline depth from input word to result word
	localparam int LATENCY    = 72;
	localparam int ROOT_STEPS = 32;
	localparam int QUO_BITS   = 31;
	localparam int N_TERMS    = 10;
	localparam int ROT_DLY    = 32;
	localparam int AXIS_DLY   = 3;
	localparam int ZERO_DLY   = 34;

	// angle constants in Q30
	localparam logic [33:0] PI_Q30      = 34'd3373259426;
	localparam logic [33:0] HALF_PI_Q30 = 34'd1686629713;
	localparam logic [33:0] TWO_PI_Q30  = 34'd6746518852;
	localparam logic [33:0] FOUR_PI_Q30 = 34'd13493037704;
	localparam logic [31:0] ONE_Q30     = 32'd1073741824;
	localparam logic [33:0] TWO_POW33   = 34'h2_0000_0000;

	// series divisors n*(n+1)
	localparam logic [8:0] SIN_DIV [N_TERMS] = '{9'd6, 9'd20, 9'd42, 9'd72, 9'd110,
		9'd156, 9'd210, 9'd272, 9'd342, 9'd420};
	localparam logic [8:0] COS_DIV [N_TERMS] = '{9'd2, 9'd12, 9'd30, 9'd56, 9'd90,
		9'd132, 9'd182, 9'd240, 9'd306, 9'd380};

	typedef struct packed {
		logic signed [31:0] rot_x;
		logic signed [31:0] rot_y;
		logic signed [31:0] rot_z;
	} rot_t;

	typedef struct packed {
		logic signed [31:0] m00;
		logic signed [31:0] m01;
		logic signed [31:0] m02;
		logic signed [31:0] m10;
		logic signed [31:0] m11;
		logic signed [31:0] m12;
		logic signed [31:0] m20;
		logic signed [31:0] m21;
		logic signed [31:0] m22;
	} mat_t;

	// product scaled down by 2^30, truncated toward zero
	function automatic logic signed [33:0] mul30(input logic signed [67:0] p);
		logic signed [67:0] adj;
		adj = p[67] ? p + 68'sd1073741823 : p;
		mul30 = $signed(adj[63:30]);
	endfunction

	// clamp to [-1.0, 1.0] in Q2.30
	function automatic logic signed [31:0] sat_q30(input logic signed [34:0] v);
		logic signed [31:0] r;
		if (v > 35'sd1073741824) begin
			r = 32'sh4000_0000;
		end else if (v < -35'sd1073741824) begin
			r = 32'shC000_0000;
		end else begin
			r = v[31:0];
		end
		sat_q30 = r;
	endfunction

endpackage

`default_nettype wire

/* sv/rotation_vector_to_matrix.sv */
// top level: rotation vector in Q4.28 to 3x3 rotation matrix in Q2.30
// depends on rvm_pkg, rvm_sqrt, rvm_div, rvm_series, rvm_merge
//
// A fully pipelined unit: a word is taken on every cycle that start is high (busy stays
// low), and its matrix appears on mat with done high for one cycle, in input order. The
// depth is set by the 32-stage square root, the 32-stage axis dividers running beside
// the angle reduction, and the ten-term series lanes at three stages per term. The
// receiver cannot stall, so results must be taken as they come.
`default_nettype none

module rotation_vector_to_matrix (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rvm_pkg::rot_t rot,
	output logic          done,
	output rvm_pkg::mat_t mat
);
	import rvm_pkg::*;

	logic [LATENCY-1:0] vld_q;
	logic signed [63:0] sqx, sqy, sqz;
	logic        [63:0] sqx_s1, sqy_s1, sqz_s1;
	rot_t               rot_s1, rot_s2;
	logic        [63:0] sum_s2;
	rot_t               rot_d [ROT_DLY];
	logic        [31:0] ang;
	rot_t               axis;
	rot_t               ax_d [AXIS_DLY];
	logic        [33:0] a4;
	logic        [33:0] r1;
	logic        [32:0] r1_s35;
	logic               zero_s35;
	logic               zero_d [ZERO_DLY];
	logic        [31:0] r_s36, r_s37, r_s38;
	logic               sn_s36, sn_s37, sn_s38, cn_s37, cn_s38;
	logic        [33:0] r1_x;
	logic        [63:0] rr;
	logic        [31:0] r2_s38;
	logic signed [33:0] sin_v, cos_v;

	assign busy = 1'b0;

	// valid chain across the whole pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LATENCY-2:0], start & ~busy};
		end
	end

	assign done = vld_q[LATENCY-1];

	// squares, then sum of squares
	always_comb begin
		sqx = rot.rot_x * rot.rot_x;
		sqy = rot.rot_y * rot.rot_y;
		sqz = rot.rot_z * rot.rot_z;
	end

	always_ff @(posedge clk) begin
		sqx_s1 <= sqx;
		sqy_s1 <= sqy;
		sqz_s1 <= sqz;
		rot_s1 <= rot;
		sum_s2 <= sqx_s1 + sqy_s1 + sqz_s1;
		rot_s2 <= rot_s1;
	end

	rvm_sqrt u_sqrt (
		.clk  (clk),
		.sum  (sum_s2),
		.root (ang)
	);

	// hold the vector until the angle is ready
	always_ff @(posedge clk) begin
		rot_d[0] <= rot_s2;
		for (int i = 1; i < ROT_DLY; i++) begin
			rot_d[i] <= rot_d[i-1];
		end
	end

	// axis lanes
	rvm_div u_div_x (.clk(clk), .num(rot_d[ROT_DLY-1].rot_x), .den(ang), .quo(axis.rot_x));
	rvm_div u_div_y (.clk(clk), .num(rot_d[ROT_DLY-1].rot_y), .den(ang), .quo(axis.rot_y));
	rvm_div u_div_z (.clk(clk), .num(rot_d[ROT_DLY-1].rot_z), .den(ang), .quo(axis.rot_z));

	always_ff @(posedge clk) begin
		ax_d[0] <= axis;
		for (int i = 1; i < AXIS_DLY; i++) begin
			ax_d[i] <= ax_d[i-1];
		end
	end

	// angle in Q30 reduced modulo two pi
	always_comb begin
		a4 = {ang, 2'b00};
		if (a4 >= FOUR_PI_Q30) begin
			r1 = a4 - FOUR_PI_Q30;
		end else if (a4 >= TWO_PI_Q30) begin
			r1 = a4 - TWO_PI_Q30;
		end else begin
			r1 = a4;
		end
	end

	always_ff @(posedge clk) begin
		r1_s35   <= r1[32:0];
		zero_s35 <= ang == 32'd0;
	end

	always_ff @(posedge clk) begin
		zero_d[0] <= zero_s35;
		for (int i = 1; i < ZERO_DLY; i++) begin
			zero_d[i] <= zero_d[i-1];
		end
	end

	// fold into the first quadrant
	assign r1_x = TWO_PI_Q30 - {1'b0, r1_s35};

	always_ff @(posedge clk) begin
		sn_s36 <= {1'b0, r1_s35} > PI_Q30;
		r_s36  <= ({1'b0, r1_s35} > PI_Q30) ? r1_x[31:0] : r1_s35[31:0];
	end

	always_ff @(posedge clk) begin
		cn_s37 <= {2'b00, r_s36} > HALF_PI_Q30;
		r_s37  <= ({2'b00, r_s36} > HALF_PI_Q30) ? PI_Q30[31:0] - r_s36 : r_s36;
		sn_s37 <= sn_s36;
	end

	// r squared in Q30
	assign rr = r_s37 * r_s37;

	always_ff @(posedge clk) begin
		r2_s38 <= rr[61:30];
		r_s38  <= r_s37;
		sn_s38 <= sn_s37;
		cn_s38 <= cn_s37;
	end

	// sine and cosine lanes
	rvm_series u_sin (
		.clk      (clk),
		.cos_lane (1'b0),
		.first    (r_s38),
		.r2       (r2_s38),
		.neg      (sn_s38),
		.sum      (sin_v)
	);

	rvm_series u_cos (
		.clk      (clk),
		.cos_lane (1'b1),
		.first    (ONE_Q30),
		.r2       (r2_s38),
		.neg      (cn_s38),
		.sum      (cos_v)
	);

	rvm_merge u_merge (
		.clk  (clk),
		.s    (sin_v),
		.c    (cos_v),
		.axis (ax_d[AXIS_DLY-1]),
		.zero (zero_d[ZERO_DLY-1]),
		.mat  (mat)
	);

endmodule

`default_nettype wire

/* sv/rvm_sqrt.sv */
// pipelined integer square root, one result bit per stage
// depends on rvm_pkg
`default_nettype none

module rvm_sqrt (
	input  logic        clk,
	input  logic [63:0] sum,
	output logic [31:0] root
);
	import rvm_pkg::*;

	logic [63:0] s_q    [ROOT_STEPS];
	logic [34:0] rem_q  [ROOT_STEPS];
	logic [31:0] root_q [ROOT_STEPS];

	genvar k;
	for (k = 0; k < ROOT_STEPS; k++) begin : g_step
		logic [63:0] s_in;
		logic [34:0] rem_in;
		logic [31:0] root_in;
		logic [34:0] rem_sh;
		logic [34:0] trial;
		logic        ge;

		if (k == 0) begin : g_first
			assign s_in    = sum;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign s_in    = s_q[k-1];
			assign rem_in  = rem_q[k-1];
			assign root_in = root_q[k-1];
		end

		// bring down the next two bits and try the next root bit
		assign rem_sh = {rem_in[32:0], s_in[63-2*k -: 2]};
		assign trial  = {1'b0, root_in, 2'b01};
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk) begin
			s_q[k]    <= s_in;
			rem_q[k]  <= ge ? rem_sh - trial : rem_sh;
			root_q[k] <= {root_in[30:0], ge};
		end
	end

	assign root = root_q[ROOT_STEPS-1];

endmodule

`default_nettype wire

/* sv/rvm_div.sv */
// one axis lane: pipelined restoring divide of a component by the angle, Q2.30 result
// depends on rvm_pkg
`default_nettype none

module rvm_div (
	input  logic               clk,
	input  logic signed [31:0] num,
	input  logic        [31:0] den,
	output logic signed [31:0] quo
);
	import rvm_pkg::*;

	logic [31:0] mag;
	logic [31:0] rem_q [QUO_BITS];
	logic [30:0] q_q   [QUO_BITS];
	logic [31:0] den_q [QUO_BITS];
	logic        neg_q [QUO_BITS];
	logic [31:0] quo_q;
	logic [31:0] qmag;

	// magnitude of the component, the sign is applied at the end
	assign mag = num[31] ? (~num + 32'd1) : num;

	genvar k;
	for (k = 0; k < QUO_BITS; k++) begin : g_step
		logic [31:0] rem_in;
		logic [30:0] q_in;
		logic [31:0] den_in;
		logic        neg_in;
		logic        nbit;
		logic [32:0] rem_sh;
		logic [32:0] den_x;
		logic        ge;

		if (k == 0) begin : g_first
			assign rem_in = {1'b0, mag[31:1]};
			assign nbit   = mag[0];
			assign q_in   = '0;
			assign den_in = den;
			assign neg_in = num[31];
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign nbit   = 1'b0;
			assign q_in   = q_q[k-1];
			assign den_in = den_q[k-1];
			assign neg_in = neg_q[k-1];
		end

		// shift in the next dividend bit and subtract where it fits
		assign rem_sh = {rem_in, nbit};
		assign den_x  = {1'b0, den_in};
		assign ge     = rem_sh >= den_x;

		always_ff @(posedge clk) begin
			rem_q[k] <= ge ? 32'(rem_sh - den_x) : rem_sh[31:0];
			q_q[k]   <= {q_in[29:0], ge};
			den_q[k] <= den_in;
			neg_q[k] <= neg_in;
		end
	end

	// restore the sign
	assign qmag = {1'b0, q_q[QUO_BITS-1]};

	always_ff @(posedge clk) begin
		quo_q <= neg_q[QUO_BITS-1] ? (~qmag + 32'd1) : qmag;
	end

	assign quo = quo_q;

endmodule

`default_nettype wire

/* sv/rvm_series.sv */
// one trig lane: ten-term taylor series, three stages per term
// depends on rvm_pkg
`default_nettype none

module rvm_series (
	input  logic               clk,
	input  logic               cos_lane,
	input  logic        [31:0] first,
	input  logic        [31:0] r2,
	input  logic               neg,
	output logic signed [33:0] sum
);
	import rvm_pkg::*;

	// stage a: scaled product
	logic        [32:0] pa_q   [N_TERMS];
	logic        [31:0] r2a_q  [N_TERMS];
	logic signed [33:0] suma_q [N_TERMS];
	logic               nega_q [N_TERMS];
	// stage b: reciprocal estimate
	logic        [31:0] qb_q   [N_TERMS];
	logic        [32:0] pb_q   [N_TERMS];
	logic        [31:0] r2b_q  [N_TERMS];
	logic signed [33:0] sumb_q [N_TERMS];
	logic               negb_q [N_TERMS];
	// stage c: corrected term and running sum
	logic        [31:0] tc_q   [N_TERMS];
	logic        [31:0] r2c_q  [N_TERMS];
	logic signed [33:0] sumc_q [N_TERMS];
	logic               negc_q [N_TERMS];
	logic signed [33:0] sum_q;

	genvar k;
	for (k = 0; k < N_TERMS; k++) begin : g_term
		localparam logic [8:0]  D_SIN = SIN_DIV[k];
		localparam logic [8:0]  D_COS = COS_DIV[k];
		localparam logic [32:0] M_SIN = 33'(TWO_POW33 / D_SIN);
		localparam logic [32:0] M_COS = 33'(TWO_POW33 / D_COS);

		logic        [8:0]  dv;
		logic        [32:0] mv;
		logic        [31:0] term_in;
		logic        [31:0] r2_in;
		logic signed [33:0] sum_in;
		logic               neg_in;
		logic        [63:0] prod_a;
		logic        [65:0] prod_b;
		logic        [40:0] qd;
		logic        [32:0] rem_c;
		logic               ge;
		logic        [31:0] q;
		logic signed [33:0] qs;

		assign dv = cos_lane ? D_COS : D_SIN;
		assign mv = cos_lane ? M_COS : M_SIN;

		if (k == 0) begin : g_first
			assign term_in = first;
			assign r2_in   = r2;
			assign sum_in  = $signed({2'b00, first});
			assign neg_in  = neg;
		end else begin : g_next
			assign term_in = tc_q[k-1];
			assign r2_in   = r2c_q[k-1];
			assign sum_in  = sumc_q[k-1];
			assign neg_in  = negc_q[k-1];
		end

		// term times r squared, back to Q30
		assign prod_a = term_in * r2_in;

		always_ff @(posedge clk) begin
			pa_q[k]   <= prod_a[62:30];
			r2a_q[k]  <= r2_in;
			suma_q[k] <= sum_in;
			nega_q[k] <= neg_in;
		end

		// quotient estimate by reciprocal, low by at most one
		assign prod_b = pa_q[k] * mv;

		always_ff @(posedge clk) begin
			qb_q[k]   <= prod_b[64:33];
			pb_q[k]   <= pa_q[k];
			r2b_q[k]  <= r2a_q[k];
			sumb_q[k] <= suma_q[k];
			negb_q[k] <= nega_q[k];
		end

		// remainder check and alternating accumulate
		assign qd    = qb_q[k] * dv;
		assign rem_c = pb_q[k] - qd[32:0];
		assign ge    = rem_c >= {24'b0, dv};
		assign q     = qb_q[k] + {31'b0, ge};
		assign qs    = $signed({2'b00, q});

		always_ff @(posedge clk) begin
			tc_q[k]   <= q;
			r2c_q[k]  <= r2b_q[k];
			sumc_q[k] <= (k % 2 == 0) ? sumb_q[k] - qs : sumb_q[k] + qs;
			negc_q[k] <= negb_q[k];
		end
	end

	// quadrant sign
	always_ff @(posedge clk) begin
		sum_q <= negc_q[N_TERMS-1] ? -sumc_q[N_TERMS-1] : sumc_q[N_TERMS-1];
	end

	assign sum = sum_q;

endmodule

`default_nettype wire

/* sv/rvm_merge.sv */
// merging stage: combines the axis lanes and the sine and cosine lanes into the matrix
// depends on rvm_pkg
`default_nettype none

module rvm_merge (
	input  logic               clk,
	input  logic signed [33:0] s,
	input  logic signed [33:0] c,
	input  rvm_pkg::rot_t      axis,
	input  logic               zero,
	output rvm_pkg::mat_t      mat
);
	import rvm_pkg::*;

	logic signed [34:0] t;
	logic signed [67:0] ptx, pty, ptz, psx, psy, psz;
	logic signed [33:0] tx_s1, ty_s1, tz_s1, sx_s1, sy_s1, sz_s1, c_s1;
	logic signed [31:0] x_s1, y_s1, z_s1;
	logic               zero_s1;
	logic signed [67:0] pxx, pxy, pxz, pyy, pyz, pzz;
	logic signed [33:0] txx_s2, txy_s2, txz_s2, tyy_s2, tyz_s2, tzz_s2;
	logic signed [33:0] sx_s2, sy_s2, sz_s2, c_s2;
	logic               zero_s2;
	mat_t               nxt;
	mat_t               mat_q;

	// one minus cosine, scaled by each axis; sine scaled by each axis
	always_comb begin
		t   = 35'sd1073741824 - {c[33], c};
		ptx = t * axis.rot_x;
		pty = t * axis.rot_y;
		ptz = t * axis.rot_z;
		psx = s * axis.rot_x;
		psy = s * axis.rot_y;
		psz = s * axis.rot_z;
	end

	always_ff @(posedge clk) begin
		tx_s1   <= mul30(ptx);
		ty_s1   <= mul30(pty);
		tz_s1   <= mul30(ptz);
		sx_s1   <= mul30(psx);
		sy_s1   <= mul30(psy);
		sz_s1   <= mul30(psz);
		c_s1    <= c;
		x_s1    <= axis.rot_x;
		y_s1    <= axis.rot_y;
		z_s1    <= axis.rot_z;
		zero_s1 <= zero;
	end

	// outer product terms
	always_comb begin
		pxx = tx_s1 * x_s1;
		pxy = tx_s1 * y_s1;
		pxz = tx_s1 * z_s1;
		pyy = ty_s1 * y_s1;
		pyz = ty_s1 * z_s1;
		pzz = tz_s1 * z_s1;
	end

	always_ff @(posedge clk) begin
		txx_s2  <= mul30(pxx);
		txy_s2  <= mul30(pxy);
		txz_s2  <= mul30(pxz);
		tyy_s2  <= mul30(pyy);
		tyz_s2  <= mul30(pyz);
		tzz_s2  <= mul30(pzz);
		sx_s2   <= sx_s1;
		sy_s2   <= sy_s1;
		sz_s2   <= sz_s1;
		c_s2    <= c_s1;
		zero_s2 <= zero_s1;
	end

	// final sums with clamping, identity for a zero vector
	always_comb begin
		nxt.m00 = sat_q30({txx_s2[33], txx_s2} + {c_s2[33], c_s2});
		nxt.m01 = sat_q30({txy_s2[33], txy_s2} - {sz_s2[33], sz_s2});
		nxt.m02 = sat_q30({txz_s2[33], txz_s2} + {sy_s2[33], sy_s2});
		nxt.m10 = sat_q30({txy_s2[33], txy_s2} + {sz_s2[33], sz_s2});
		nxt.m11 = sat_q30({tyy_s2[33], tyy_s2} + {c_s2[33], c_s2});
		nxt.m12 = sat_q30({tyz_s2[33], tyz_s2} - {sx_s2[33], sx_s2});
		nxt.m20 = sat_q30({txz_s2[33], txz_s2} - {sy_s2[33], sy_s2});
		nxt.m21 = sat_q30({tyz_s2[33], tyz_s2} + {sx_s2[33], sx_s2});
		nxt.m22 = sat_q30({tzz_s2[33], tzz_s2} + {c_s2[33], c_s2});
		if (zero_s2) begin
			nxt     = '0;
			nxt.m00 = ONE_Q30;
			nxt.m11 = ONE_Q30;
			nxt.m22 = ONE_Q30;
		end
	end

	always_ff @(posedge clk) begin
		mat_q <= nxt;
	end

	assign mat = mat_q;

endmodule

`default_nettype wire

/* sv/rvm_checker.sv */
// port-level checks for the rotation vector to matrix block, bound to the top level
// depends on rvm_pkg and rotation_vector_to_matrix
`default_nettype none

module rvm_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input rvm_pkg::rot_t rot,
	input logic          done,
	input rvm_pkg::mat_t mat
);
	import rvm_pkg::*;

	// the pipe takes a word every cycle
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// every word gives a result after the fixed depth
	a_word_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result missing");

	// no result without a word taken earlier
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("unexpected result");

	// zero vector gives the identity
	a_zero_ident: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && rot == '0) |-> ##LATENCY
		(mat.m00 == 32'sh4000_0000 && mat.m11 == 32'sh4000_0000 &&
		mat.m22 == 32'sh4000_0000 && mat.m01 == 32'sh0 && mat.m02 == 32'sh0 &&
		mat.m10 == 32'sh0 && mat.m12 == 32'sh0 && mat.m20 == 32'sh0 && mat.m21 == 32'sh0))
		else $error("zero vector not identity");

	// diagonal entries stay within one
	a_diag_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (mat.m00 <= 32'sh4000_0000 && mat.m00 >= 32'shC000_0000 &&
		mat.m11 <= 32'sh4000_0000 && mat.m11 >= 32'shC000_0000 &&
		mat.m22 <= 32'sh4000_0000 && mat.m22 >= 32'shC000_0000))
		else $error("diagonal out of range");

endmodule

bind rotation_vector_to_matrix rvm_checker u_rvm_checker (.*);

`default_nettype wire
